/* sv/tape_machine_interpreter_core_assert.svh */
// Assertion macros shared by the tape machine interpreter core.
`ifndef TAPE_MACHINE_INTERPRETER_CORE_ASSERT_SVH
`define TAPE_MACHINE_INTERPRETER_CORE_ASSERT_SVH

// Check a consequence in the same cycle as its antecedent.
`define TMI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tape machine same-cycle check failed");

// Check a consequence in the cycle after its antecedent.
`define TMI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tape machine next-cycle check failed");

`endif

/* sv/tmi_pkg.sv */
// Shared types and constants of the tape machine interpreter core.
package tmi_pkg;

  // Instruction characters
  localparam logic [7:0] CH_OPEN  = 8'h5B;  // [
  localparam logic [7:0] CH_CLOSE = 8'h5D;  // ]
  localparam logic [7:0] CH_GT    = 8'h3E;  // >
  localparam logic [7:0] CH_LT    = 8'h3C;  // <
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // +
  localparam logic [7:0] CH_MINUS = 8'h2D;  // -
  localparam logic [7:0] CH_DOT   = 8'h2E;  // .
  localparam logic [7:0] CH_COMMA = 8'h2C;  // ,
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // Result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_INVALID = 2'd1;
  localparam logic [1:0] STAT_UNBAL   = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SEEK,
    ST_TEST,
    ST_RESP
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic clear;    // write one zero into the tape
    logic accept;   // capture the request, write the program if it is a load
    logic exec;     // execute the fetched instruction
    logic seek;     // step the bracket scan pointer
    logic test;     // examine the scanned character
    logic respond;  // load the result register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clr_done;
    logic run_step;
    logic scan_start;
    logic seek_fail;
    logic scan_hit;
    logic out_free;
  } sts_t;

endpackage

/* sv/tmi_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tmi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/tmi_ctrl.sv */
// Controller state machine of the tape machine interpreter core.
module tmi_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  tmi_pkg::sts_t sts,
  output tmi_pkg::cmd_t cmd
);

  tmi_pkg::state_t state, state_next;

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tmi_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Choose the next state
  always_comb begin
    state_next = state;
    unique case (state)
      tmi_pkg::ST_CLEAR: begin
        if (sts.clr_done) state_next = tmi_pkg::ST_IDLE;
      end
      tmi_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = sts.run_step ? tmi_pkg::ST_EXEC : tmi_pkg::ST_RESP;
        end
      end
      tmi_pkg::ST_EXEC: begin
        state_next = sts.scan_start ? tmi_pkg::ST_SEEK : tmi_pkg::ST_RESP;
      end
      tmi_pkg::ST_SEEK: begin
        state_next = sts.seek_fail ? tmi_pkg::ST_RESP : tmi_pkg::ST_TEST;
      end
      tmi_pkg::ST_TEST: begin
        state_next = sts.scan_hit ? tmi_pkg::ST_RESP : tmi_pkg::ST_SEEK;
      end
      tmi_pkg::ST_RESP: begin
        if (sts.out_free) state_next = tmi_pkg::ST_IDLE;
      end
      default: state_next = tmi_pkg::ST_CLEAR;
    endcase
  end

  // Drive commands and ready
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      tmi_pkg::ST_CLEAR: cmd.clear = 1'b1;
      tmi_pkg::ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
      end
      tmi_pkg::ST_EXEC: cmd.exec = 1'b1;
      tmi_pkg::ST_SEEK: cmd.seek = 1'b1;
      tmi_pkg::ST_TEST: cmd.test = 1'b1;
      tmi_pkg::ST_RESP: cmd.respond = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

/* sv/tmi_dpath.sv */
// Datapath of the tape machine interpreter core: memories, pointers, result register.
module tmi_dpath #(
  parameter int TAPE_CELLS = 1024,
  parameter int PROG_DEPTH = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  tmi_pkg::cmd_t cmd,
  output tmi_pkg::sts_t sts,
  input  logic [31:0]   s_tdata,
  input  logic          s_tlast,
  input  logic          s_tuser,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [39:0]   m_tdata,
  output logic          m_tuser
);

  localparam int DW  = $clog2(TAPE_CELLS);
  localparam int PAW = $clog2(PROG_DEPTH);
  localparam int IW  = PAW + 1;
  localparam int XW  = ((PAW > 10) ? PAW : 10) + 1;
  localparam int TXW = (DW > 10) ? DW : 10;
  localparam int IXW = (IW > 11) ? IW : 11;

  // Architectural state
  logic [DW-1:0] dp;
  logic [IW-1:0] ip;
  logic [IW-1:0] plen;
  logic          err;
  logic [DW-1:0] clr_addr;

  // Per-request working registers
  logic [7:0]    byte_q;
  logic          ov;
  logic [7:0]    ob;
  logic          taken;
  logic          inval;
  logic [IW-1:0] p;
  logic [IW-1:0] depth;
  logic          fwd;

  // Memory ports
  logic [7:0]     prog_rdata;
  logic [7:0]     tape_rdata;
  logic           prog_we;
  logic [PAW-1:0] prog_raddr;
  logic           tape_we;
  logic [DW-1:0]  tape_waddr;
  logic [7:0]     tape_wdata;

  // Request fields
  logic [9:0]    addr_in;
  logic [7:0]    char_in;
  logic [7:0]    byte_in;
  logic [XW-1:0] addr_x;
  logic [XW-1:0] len_x;
  logic [XW-1:0] len_sat;
  logic          addr_ok;

  // Execute and scan terms
  logic [DW-1:0] dp_inc;
  logic [DW-1:0] dp_dec;
  logic [7:0]    exec_wdata;
  logic          exec_we;
  logic [IW-1:0] p_fwd;
  logic [IW-1:0] p_step;
  logic [7:0]    same_br;
  logic [7:0]    opp_br;
  logic [IW-1:0] depth_nx;

  // Result terms
  logic [TXW-1:0] dp_x;
  logic [IXW-1:0] ip_x;
  logic [1:0]     status;
  logic           halted;

  assign addr_in = s_tdata[9:0];
  assign char_in = s_tdata[17:10];
  assign byte_in = s_tdata[25:18];

  // Decode the load address and saturate the program length
  assign addr_x  = XW'(addr_in);
  assign addr_ok = addr_x < XW'(PROG_DEPTH);
  assign len_x   = addr_x + 1'b1;
  assign len_sat = (len_x > XW'(PROG_DEPTH)) ? XW'(PROG_DEPTH) : len_x;
  assign prog_we = cmd.accept && !s_tuser && addr_ok;

  // Wrap the data pointer at the tape size
  assign dp_inc = (dp == DW'(TAPE_CELLS - 1)) ? '0 : dp + 1'b1;
  assign dp_dec = (dp == '0) ? DW'(TAPE_CELLS - 1) : dp - 1'b1;

  // Cell write for plus, minus and comma
  always_comb begin
    exec_we    = 1'b0;
    exec_wdata = byte_q;
    case (prog_rdata)
      tmi_pkg::CH_PLUS: begin
        exec_we    = 1'b1;
        exec_wdata = tape_rdata + 8'd1;
      end
      tmi_pkg::CH_MINUS: begin
        exec_we    = 1'b1;
        exec_wdata = tape_rdata - 8'd1;
      end
      tmi_pkg::CH_COMMA: exec_we = 1'b1;
      default: exec_we = 1'b0;
    endcase
  end

  assign tape_we    = cmd.clear || (cmd.exec && exec_we);
  assign tape_waddr = cmd.clear ? clr_addr : dp;
  assign tape_wdata = cmd.clear ? 8'd0 : exec_wdata;

  // Bracket scan stepping and nesting count
  assign p_fwd    = p + 1'b1;
  assign p_step   = fwd ? p_fwd : p - 1'b1;
  assign same_br  = fwd ? tmi_pkg::CH_OPEN : tmi_pkg::CH_CLOSE;
  assign opp_br   = fwd ? tmi_pkg::CH_CLOSE : tmi_pkg::CH_OPEN;
  assign depth_nx = (prog_rdata == same_br) ? depth + 1'b1 :
                    (prog_rdata == opp_br)  ? depth - 1'b1 : depth;

  assign prog_raddr = cmd.seek ? p_step[PAW-1:0] : ip[PAW-1:0];

  // Report status to the controller
  always_comb begin
    sts            = '0;
    sts.clr_done   = clr_addr == DW'(TAPE_CELLS - 1);
    sts.run_step   = s_tuser && !err && (ip < plen);
    sts.scan_start = ((prog_rdata == tmi_pkg::CH_OPEN) && (tape_rdata == 8'd0)) ||
                     ((prog_rdata == tmi_pkg::CH_CLOSE) && (tape_rdata != 8'd0));
    sts.seek_fail  = fwd ? (p_fwd >= plen) : (p == '0);
    sts.scan_hit   = (prog_rdata == opp_br) && (depth == IW'(1));
    sts.out_free   = !m_tvalid || m_tready;
  end

  // Update the architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      dp       <= '0;
      ip       <= '0;
      plen     <= '0;
      err      <= 1'b0;
      clr_addr <= '0;
    end else begin
      if (cmd.clear) clr_addr <= clr_addr + 1'b1;
      if (cmd.accept && !s_tuser && s_tlast) begin
        plen <= IW'(len_sat);
        ip   <= '0;
      end
      if (cmd.exec) begin
        case (prog_rdata)
          tmi_pkg::CH_GT: dp <= dp_inc;
          tmi_pkg::CH_LT: dp <= dp_dec;
          default: dp <= dp;
        endcase
        if (!sts.scan_start) ip <= ip + 1'b1;
      end
      if (cmd.seek && sts.seek_fail) err <= 1'b1;
      if (cmd.test && sts.scan_hit) ip <= p + 1'b1;
    end
  end

  // Track the request flags and the scan
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_q <= byte_in;
      ov     <= 1'b0;
      ob     <= 8'd0;
      taken  <= 1'b0;
      inval  <= 1'b0;
    end
    if (cmd.exec) begin
      case (prog_rdata) inside
        tmi_pkg::CH_DOT: begin
          ov <= 1'b1;
          ob <= tape_rdata;
        end
        tmi_pkg::CH_COMMA: taken <= 1'b1;
        tmi_pkg::CH_OPEN, tmi_pkg::CH_CLOSE, tmi_pkg::CH_GT, tmi_pkg::CH_LT,
        tmi_pkg::CH_PLUS, tmi_pkg::CH_MINUS, tmi_pkg::CH_SPACE, tmi_pkg::CH_NL: begin
          inval <= 1'b0;
        end
        default: inval <= 1'b1;
      endcase
      if (sts.scan_start) begin
        p     <= ip;
        depth <= IW'(1);
        fwd   <= prog_rdata == tmi_pkg::CH_OPEN;
      end
    end
    if (cmd.seek && !sts.seek_fail) p <= p_step;
    if (cmd.test) depth <= depth_nx;
  end

  // Form the result fields
  assign dp_x   = TXW'(dp);
  assign ip_x   = IXW'(ip);
  assign halted = err || (ip >= plen);
  assign status = err ? tmi_pkg::STAT_UNBAL :
                  inval ? tmi_pkg::STAT_INVALID : tmi_pkg::STAT_OK;

  // Hold the result until the downstream side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.respond) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      m_tuser <= ov;
      m_tdata <= {7'd0, ip_x[10:0], halted, status, taken, dp_x[9:0], ob};
    end
  end

  tmi_ram #(.WIDTH(8), .DEPTH(PROG_DEPTH)) u_prog (
    .clk   (clk),
    .we    (prog_we),
    .waddr (addr_x[PAW-1:0]),
    .wdata (char_in),
    .raddr (prog_raddr),
    .rdata (prog_rdata)
  );

  tmi_ram #(.WIDTH(8), .DEPTH(TAPE_CELLS)) u_tape (
    .clk   (clk),
    .we    (tape_we),
    .waddr (tape_waddr),
    .wdata (tape_wdata),
    .raddr (dp),
    .rdata (tape_rdata)
  );

endmodule

/* sv/tape_machine_interpreter_core.sv */
// A load request, or a step on a halted program, goes from the idle state that
// accepts it straight to respond; a running step passes through execute first.
// A bracket jump adds a seek and a test state for each program character it reads,
// and a scan that runs off the program without a match ends in an extra seek state.
// One request at a time goes through accept, execute and respond; respond waits
// until no earlier result is held, then loads the result register and raises m_tvalid.
// Reset: the tape is cleared one cell a cycle, all TAPE_CELLS cells, with s_tready low.
`include "tape_machine_interpreter_core_assert.svh"

module tape_machine_interpreter_core #(
  parameter int TAPE_CELLS = 1024,
  parameter int PROG_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // prog_addr[9:0], prog_char[17:10], in_byte[25:18]
  input  logic        s_tlast,   // last_char
  input  logic        s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // out_byte[7:0], out_cell[17:8], input_taken[18],
                                 // status[20:19], halted[21], instr_index[32:22]
  output logic        m_tuser    // out_valid
);

  tmi_pkg::cmd_t cmd;
  tmi_pkg::sts_t sts;

  tmi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tmi_dpath #(.TAPE_CELLS(TAPE_CELLS), .PROG_DEPTH(PROG_DEPTH)) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Only one request is in flight at a time
  `TMI_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
  // Execution follows directly on an accepted request
  `TMI_ASSERT_NOW(a_exec_after_accept, cmd.exec, $past(s_tvalid && s_tready))
  // No request is taken while the tape is being cleared
  `TMI_ASSERT_NOW(a_no_accept_in_clear, cmd.clear, !s_tready)

endmodule

/* tb/tb_tape_machine_interpreter_core.sv */
// Self-checking testbench for the tape machine interpreter core: directed table, random programs.
module tb_tape_machine_interpreter_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAPE_CELLS  = 1024;
  localparam int PROG_DEPTH  = 1024;
  localparam int ITEM_TARGET = 850;
  localparam int CALM_ITEMS  = 120;
  localparam int LONG_HOLD   = 400;
  localparam int TAIL_CYCLES = 40;
  localparam int CYCLE_LIMIT = 800000;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef struct packed {
    logic       op;
    logic [9:0] prog_addr;
    logic [7:0] prog_char;
    logic       last_char;
    logic [7:0] in_byte;
  } tape_req_t;

  typedef struct packed {
    logic        out_valid;
    logic [7:0]  out_byte;
    logic [9:0]  out_cell;
    logic        input_taken;
    logic [1:0]  status;
    logic        halted;
    logic [10:0] instr_index;
  } tape_res_t;

  typedef struct {
    tape_req_t req;
    bit        typed;
    tape_res_t res;
  } dir_row_t;

  localparam tape_res_t NO_RESULT = '0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tuser;

  // Interpreter state as the testbench sees it
  bit [7:0]    prog_mem [PROG_DEPTH];
  bit          prog_written [PROG_DEPTH];
  bit [7:0]    tape_mem [TAPE_CELLS];
  logic [9:0]  data_ptr = '0;
  logic [10:0] instr_ptr = '0;
  logic [10:0] prog_len = '0;
  bit          err_flag = 1'b0;

  tape_res_t   expected_results [$];
  dir_row_t    directed_rows [$];
  tape_res_t   want;
  int          failures = 0;
  int          sent = 0;
  int          cycles = 0;
  int          gap_pct = 20;
  bit          calm = 1'b0;
  int          hold_reqs = 0;
  int          holds_done = 0;
  bit          paused = 1'b0;

  tape_machine_interpreter_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tape_machine_interpreter_core regression: fail");
      $finish;
    end
  end

  // Advance the interpreter by one request and return the result it gives
  function automatic tape_res_t run_interpreter(input tape_req_t r);
    tape_res_t  res;
    logic [7:0] c;
    int         depth;
    int         p;
    bit         found;
    res = '0;
    found = 1'b1;
    if (r.op == OP_LOAD) begin
      prog_mem[r.prog_addr] = r.prog_char;
      prog_written[r.prog_addr] = 1'b1;
      if (r.last_char) begin
        prog_len = {1'b0, r.prog_addr} + 11'd1;
        instr_ptr = '0;
      end
    end else if (!err_flag && instr_ptr < prog_len) begin
      c = prog_mem[instr_ptr[9:0]];
      case (c)
        tmi_pkg::CH_GT:    data_ptr = data_ptr + 10'd1;
        tmi_pkg::CH_LT:    data_ptr = data_ptr - 10'd1;
        tmi_pkg::CH_PLUS:  tape_mem[data_ptr] = tape_mem[data_ptr] + 8'd1;
        tmi_pkg::CH_MINUS: tape_mem[data_ptr] = tape_mem[data_ptr] - 8'd1;
        tmi_pkg::CH_DOT: begin
          res.out_valid = 1'b1;
          res.out_byte = tape_mem[data_ptr];
        end
        tmi_pkg::CH_COMMA: begin
          res.input_taken = 1'b1;
          tape_mem[data_ptr] = r.in_byte;
        end
        tmi_pkg::CH_OPEN: begin
          // scan forward for the matching close bracket
          if (tape_mem[data_ptr] == 8'd0) begin
            found = 1'b0;
            depth = 1;
            p = instr_ptr;
            while (!found && p + 1 < prog_len) begin
              p++;
              if (prog_mem[10'(p)] == tmi_pkg::CH_OPEN) depth++;
              if (prog_mem[10'(p)] == tmi_pkg::CH_CLOSE) depth--;
              if (depth == 0) begin
                found = 1'b1;
                instr_ptr = 11'(p);
              end
            end
          end
        end
        tmi_pkg::CH_CLOSE: begin
          // scan backward for the matching open bracket
          if (tape_mem[data_ptr] != 8'd0) begin
            found = 1'b0;
            depth = -1;
            p = instr_ptr;
            while (!found && p > 0) begin
              p--;
              if (prog_mem[10'(p)] == tmi_pkg::CH_OPEN) depth++;
              if (prog_mem[10'(p)] == tmi_pkg::CH_CLOSE) depth--;
              if (depth == 0) begin
                found = 1'b1;
                instr_ptr = 11'(p);
              end
            end
          end
        end
        tmi_pkg::CH_SPACE, tmi_pkg::CH_NL: ;
        default: res.status = tmi_pkg::STAT_INVALID;
      endcase
      if (found) instr_ptr = instr_ptr + 11'd1;
      else err_flag = 1'b1;
    end
    if (err_flag) res.status = tmi_pkg::STAT_UNBAL;
    res.out_cell = data_ptr;
    res.halted = err_flag || instr_ptr >= prog_len;
    res.instr_index = instr_ptr;
    return res;
  endfunction

  // A step may run only over written entries with matched brackets
  function automatic bit step_is_safe();
    int depth;
    if (err_flag || instr_ptr >= prog_len) return 1'b1;
    depth = 0;
    for (int i = 0; i < prog_len; i++) begin
      if (!prog_written[10'(i)]) return 1'b0;
      if (prog_mem[10'(i)] == tmi_pkg::CH_OPEN) depth++;
      if (prog_mem[10'(i)] == tmi_pkg::CH_CLOSE) begin
        if (depth == 0) return 1'b0;
        depth--;
      end
    end
    return depth == 0;
  endfunction

  // Pick a non-bracket character: commands, blanks and now and then an invalid byte
  function automatic logic [7:0] pick_char();
    logic [7:0] c;
    int         roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) return tmi_pkg::CH_PLUS;
    if (roll < 40) return tmi_pkg::CH_MINUS;
    if (roll < 52) return tmi_pkg::CH_GT;
    if (roll < 64) return tmi_pkg::CH_LT;
    if (roll < 74) return tmi_pkg::CH_DOT;
    if (roll < 84) return tmi_pkg::CH_COMMA;
    if (roll < 89) return tmi_pkg::CH_SPACE;
    if (roll < 94) return tmi_pkg::CH_NL;
    forever begin
      c = 8'($urandom_range(0, 255));
      case (c)
        tmi_pkg::CH_OPEN, tmi_pkg::CH_CLOSE, tmi_pkg::CH_GT, tmi_pkg::CH_LT,
        tmi_pkg::CH_PLUS, tmi_pkg::CH_MINUS, tmi_pkg::CH_DOT, tmi_pkg::CH_COMMA,
        tmi_pkg::CH_SPACE, tmi_pkg::CH_NL: ;
        default: return c;
      endcase
    end
  endfunction

  function automatic tape_req_t load_req(logic [9:0] addr, logic [7:0] ch, logic last);
    tape_req_t r;
    r.op = OP_LOAD;
    r.prog_addr = addr;
    r.prog_char = ch;
    r.last_char = last;
    r.in_byte = 8'($urandom_range(0, 255));
    return r;
  endfunction

  function automatic tape_req_t step_req(logic [7:0] inb);
    tape_req_t r;
    r.op = OP_STEP;
    r.prog_addr = 10'($urandom_range(0, 1023));
    r.prog_char = 8'($urandom_range(0, 255));
    r.last_char = 1'($urandom_range(0, 1));
    r.in_byte = inb;
    return r;
  endfunction

  function automatic tape_res_t res_of(logic ov, logic [7:0] ob, logic [9:0] cell_idx,
                                       logic taken, logic [1:0] st, logic halted,
                                       logic [10:0] ip);
    tape_res_t res;
    res.out_valid = ov;
    res.out_byte = ob;
    res.out_cell = cell_idx;
    res.input_taken = taken;
    res.status = st;
    res.halted = halted;
    res.instr_index = ip;
    return res;
  endfunction

  function automatic void add_row(bit typed, logic op, logic [9:0] addr, logic [7:0] ch,
                                  logic last, logic [7:0] inb, tape_res_t res);
    dir_row_t row;
    row.req.op = op;
    row.req.prog_addr = addr;
    row.req.prog_char = ch;
    row.req.last_char = last;
    row.req.in_byte = inb;
    row.typed = typed;
    row.res = res;
    directed_rows.push_back(row);
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      failures++;
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
    end
  endfunction

  // Offer one request, log its expected result once accepted, then maybe idle
  task automatic send_request(input tape_req_t r, input bit typed, input tape_res_t typed_res);
    tape_res_t predicted;
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, r.in_byte, r.prog_char, r.prog_addr};
    s_tlast <= r.last_char;
    s_tuser <= r.op;
    do @(posedge clk); while (!s_tready);
    predicted = run_interpreter(r);
    expected_results.push_back(typed ? typed_res : predicted);
    sent++;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic send_step();
    if (step_is_safe()) send_request(step_req(8'($urandom_range(0, 255))), 1'b0, NO_RESULT);
  endtask

  // Drop the request valid and hold off until every result has come
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Load a random program with matched brackets, then run it for a while
  task automatic random_program();
    int         len;
    int         open_cnt;
    int         room;
    int         roll;
    int         cut;
    logic [7:0] ch;
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
    // now and then abandon the load part way, leaving the old program in charge
    cut = ($urandom_range(0, 99) < 8) ? $urandom_range(0, len - 1) : len;
    open_cnt = 0;
    for (int i = 0; i < cut; i++) begin
      room = len - i;
      roll = $urandom_range(0, 99);
      if (open_cnt > 0 && room == open_cnt) begin
        ch = tmi_pkg::CH_CLOSE;
        open_cnt--;
      end else if (roll < 12 && room - 1 > open_cnt) begin
        ch = tmi_pkg::CH_OPEN;
        open_cnt++;
      end else if (roll < 22 && open_cnt > 0) begin
        ch = tmi_pkg::CH_CLOSE;
        open_cnt--;
      end else begin
        ch = pick_char();
      end
      send_request(load_req(10'(i), ch, i == len - 1), 1'b0, NO_RESULT);
    end
    repeat ($urandom_range(1, 2 * len + 6)) send_step();
  endtask

  // Stray loads and steps that break up the well-formed traffic
  task automatic line_noise();
    case ($urandom_range(0, 3))
      0: send_request(load_req(10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)),
                               1'b0), 1'b0, NO_RESULT);
      1: send_request(load_req(10'($urandom_range(0, 31)),
                               ($urandom_range(0, 3) == 0) ? tmi_pkg::CH_OPEN : pick_char(),
                               1'b1),
                      1'b0, NO_RESULT);
      2: repeat ($urandom_range(1, 4)) send_step();
      default: send_request(load_req($urandom_range(0, 1) ? 10'd1023 : 10'd0,
                                     $urandom_range(0, 1) ? 8'hFF : 8'h00, 1'b0),
                            1'b0, NO_RESULT);
    endcase
  endtask

  // Drive the result side ready, with random stalls and one long hold-off
  initial begin : ready_gen
    int stall_pct;
    stall_pct = 20;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 149) == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 15;
          default: stall_pct = 40;
        endcase
      end
      if (hold_reqs != holds_done) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done++;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        failures++;
        $error("result with no request outstanding");
      end else begin
        want = expected_results.pop_front();
        check_field("out_valid", want.out_valid, m_tuser);
        check_field("out_byte", want.out_byte, m_tdata[7:0]);
        check_field("out_cell", want.out_cell, m_tdata[17:8]);
        check_field("input_taken", want.input_taken, m_tdata[18]);
        check_field("status", want.status, m_tdata[20:19]);
        check_field("halted", want.halted, m_tdata[21]);
        check_field("instr_index", want.instr_index, m_tdata[32:22]);
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed program: wrap left, cell wrap, output, a loop taken back once,
    // a forward skip, blanks, an invalid byte and a wrap right
    add_row(1, OP_STEP, 10'd0, 8'h00, 0, 8'd0,
            res_of(0, 0, 0, 0, tmi_pkg::STAT_OK, 1, 0));
    add_row(1, OP_LOAD, 10'd0,  tmi_pkg::CH_LT,    0, 8'd0,
            res_of(0, 0, 0, 0, tmi_pkg::STAT_OK, 1, 0));
    add_row(1, OP_LOAD, 10'd1,  tmi_pkg::CH_MINUS, 0, 8'd0,
            res_of(0, 0, 0, 0, tmi_pkg::STAT_OK, 1, 0));
    add_row(1, OP_LOAD, 10'd2,  tmi_pkg::CH_DOT,   0, 8'd0,
            res_of(0, 0, 0, 0, tmi_pkg::STAT_OK, 1, 0));
    add_row(1, OP_LOAD, 10'd3,  tmi_pkg::CH_OPEN,  0, 8'd0,
            res_of(0, 0, 0, 0, tmi_pkg::STAT_OK, 1, 0));
    add_row(1, OP_LOAD, 10'd4,  tmi_pkg::CH_COMMA, 0, 8'd0,
            res_of(0, 0, 0, 0, tmi_pkg::STAT_OK, 1, 0));
    add_row(1, OP_LOAD, 10'd5,  tmi_pkg::CH_PLUS,  0, 8'd0,
            res_of(0, 0, 0, 0, tmi_pkg::STAT_OK, 1, 0));
    add_row(1, OP_LOAD, 10'd6,  tmi_pkg::CH_CLOSE, 0, 8'd0,
            res_of(0, 0, 0, 0, tmi_pkg::STAT_OK, 1, 0));
    add_row(1, OP_LOAD, 10'd7,  tmi_pkg::CH_OPEN,  0, 8'd0,
            res_of(0, 0, 0, 0, tmi_pkg::STAT_OK, 1, 0));
    add_row(1, OP_LOAD, 10'd8,  tmi_pkg::CH_SPACE, 0, 8'd0,
            res_of(0, 0, 0, 0, tmi_pkg::STAT_OK, 1, 0));
    add_row(1, OP_LOAD, 10'd9,  tmi_pkg::CH_CLOSE, 0, 8'd0,
            res_of(0, 0, 0, 0, tmi_pkg::STAT_OK, 1, 0));
    add_row(1, OP_LOAD, 10'd10, tmi_pkg::CH_NL,    0, 8'd0,
            res_of(0, 0, 0, 0, tmi_pkg::STAT_OK, 1, 0));
    add_row(1, OP_LOAD, 10'd11, 8'hFF,             0, 8'd0,
            res_of(0, 0, 0, 0, tmi_pkg::STAT_OK, 1, 0));
    add_row(1, OP_LOAD, 10'd12, tmi_pkg::CH_GT,    1, 8'd0,
            res_of(0, 0, 0, 0, tmi_pkg::STAT_OK, 0, 0));
    add_row(1, OP_STEP, 10'd0, 8'h00, 0, 8'd0,
            res_of(0, 0, 1023, 0, tmi_pkg::STAT_OK, 0, 1));
    add_row(0, OP_STEP, 10'd0, 8'h00, 0, 8'd0, NO_RESULT);
    add_row(1, OP_STEP, 10'd0, 8'h00, 0, 8'd0,
            res_of(1, 255, 1023, 0, tmi_pkg::STAT_OK, 0, 3));
    add_row(0, OP_STEP, 10'd0, 8'h00, 0, 8'd0, NO_RESULT);
    add_row(0, OP_STEP, 10'd0, 8'h00, 0, 8'd0, NO_RESULT);
    add_row(0, OP_STEP, 10'd0, 8'h00, 0, 8'd0, NO_RESULT);
    add_row(0, OP_STEP, 10'd0, 8'h00, 0, 8'd0, NO_RESULT);
    add_row(0, OP_STEP, 10'h3FF, 8'hFF, 1, 8'd255, NO_RESULT);
    add_row(0, OP_STEP, 10'd0, 8'h00, 0, 8'd0, NO_RESULT);
    add_row(0, OP_STEP, 10'd0, 8'h00, 0, 8'd0, NO_RESULT);
    add_row(0, OP_STEP, 10'd0, 8'h00, 0, 8'd0, NO_RESULT);
    add_row(0, OP_STEP, 10'd0, 8'h00, 0, 8'd0, NO_RESULT);
    add_row(1, OP_STEP, 10'd0, 8'h00, 0, 8'd0,
            res_of(0, 0, 1023, 0, tmi_pkg::STAT_INVALID, 0, 12));
    add_row(1, OP_STEP, 10'd0, 8'h00, 0, 8'd0,
            res_of(0, 0, 0, 0, tmi_pkg::STAT_OK, 1, 13));
    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);

    // Random programs with stray traffic mixed in
    while (sent < ITEM_TARGET) begin
      if (sent >= 350 && hold_reqs == 0) hold_reqs = 1;
      if (sent >= 550 && !paused) begin
        paused = 1'b1;
        wait_for_results();
      end
      if (sent >= ITEM_TARGET - CALM_ITEMS) calm = 1'b1;
      if ($urandom_range(0, 29) == 0) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 20;
          default: gap_pct = 50;
        endcase
      end
      if ($urandom_range(0, 99) < 75) random_program();
      else line_noise();
    end

    // Trip the sticky bracket error, then keep loading and stepping while halted
    send_request(load_req(10'd0, tmi_pkg::CH_COMMA, 1'b0), 1'b0, NO_RESULT);
    send_request(load_req(10'd1, tmi_pkg::CH_OPEN, 1'b1), 1'b0, NO_RESULT);
    send_request(step_req(8'd0), 1'b0, NO_RESULT);
    send_request(step_req(8'($urandom_range(0, 255))), 1'b0, NO_RESULT);
    send_request(load_req(10'd1023, 8'($urandom_range(0, 255)), 1'b1), 1'b0, NO_RESULT);
    repeat (30) begin
      if ($urandom_range(0, 1))
        send_request(load_req(10'($urandom_range(0, 1023)), pick_char(),
                              1'($urandom_range(0, 1))), 1'b0, NO_RESULT);
      else
        send_request(step_req(8'($urandom_range(0, 255))), 1'b0, NO_RESULT);
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("tape_machine_interpreter_core regression: pass");
    end else begin
      $display("tape_machine_interpreter_core regression: fail");
    end
    $finish;
  end

endmodule
